// ===== design/wsp_pkg.sv =====
package wsp_pkg;

  localparam logic [1:0] OP_LOAD_VIEW = 2'd0;
  localparam logic [1:0] OP_LOAD_PROJ = 2'd1;
  localparam logic [1:0] OP_PROJECT   = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CAMERA = 2'd2;

  // Sideband that travels with every word through the transform stages.
  typedef struct packed {
    logic        vld;
    logic [1:0]  op;
    logic [3:0]  idx;
    logic [31:0] val;
  } tag_t;

  // Sideband after the transforms: res marks a word that gives a result,
  // ok marks a result that is actually projected.
  typedef struct packed {
    logic vld;
    logic res;
    logic ok;
  } meta_t;

endpackage

// ===== design/world_to_screen_projection_top.sv =====
// World-to-screen projection pipeline.
// Input stream: in_tuser carries the opcode. Load words write one element of
// the view or projection matrix (column-major, index = column*4 + row) and
// give no result; project words carry a world point and give one result word.
// Opcode 3 is dropped without a result.
// Output stream: screen x/y in tdata, projected and on-screen flags in tuser.
// Configuration: cfg_we writes screen width, screen height or camera valid,
// selected by cfg_addr; write only while the pipeline is empty.
// The pipeline is one input stage, two stages for each matrix transform, one
// stage per quotient bit of the 32 + FRAC_BITS bit divider plus two around it,
// and two stages of screen mapping (Q16.16 by default). Throughput is one word
// per cycle while the receiver does not stall.
// A receiver stall freezes every stage at once; in_tready falls while the
// output word waits and nothing is lost or repeated.
// Reset clears both matrices to zero, restores 1920x1080 with the camera
// invalid, and empties the pipeline.
module world_to_screen_projection_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // element_index[3:0], element_value[35:4], point_x[67:36],
  // point_y[99:68], point_z[131:100], zero pad
  input  logic [135:0]  in_tdata,
  // opcode[1:0]
  input  logic [1:0]    in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // screen_x[31:0], screen_y[63:32]
  output logic [63:0]   out_tdata,
  // projected[0], on_screen[1]
  output logic [1:0]    out_tuser,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_addr,
  input  logic [13:0]   cfg_wdata
);
  import wsp_pkg::*;

  localparam int DW = 32 + FRAC_BITS;
  localparam logic signed [31:0] W_MIN = 32'((2 ** FRAC_BITS + 999) / 1000);
  localparam logic signed [31:0] FX_ONE = 32'(2 ** FRAC_BITS);

  logic [13:0] width_r, height_r;
  logic        cam_r;
  logic        ce;
  tag_t        tag0_r, tag1, tag2;
  logic signed [31:0] pt_r [4];
  logic signed [31:0] vp [4];
  logic signed [31:0] cp [4];
  meta_t       meta_c, meta_d;
  logic signed [DW:0] nx, ny;
  logic signed [31:0] sx, sy;
  logic        proj, vis;

  assign ce        = !out_tvalid || out_tready;
  assign in_tready = ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 14'd1920;
      height_r <= 14'd1080;
      cam_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        REG_CAMERA: cam_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) tag0_r.vld <= 1'b0;
    else if (ce) tag0_r.vld <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      tag0_r.op  <= in_tuser;
      tag0_r.idx <= in_tdata[3:0];
      tag0_r.val <= in_tdata[35:4];
      pt_r[0]    <= in_tdata[67:36];
      pt_r[1]    <= in_tdata[99:68];
      pt_r[2]    <= in_tdata[131:100];
      pt_r[3]    <= FX_ONE;
    end
  end

  wsp_xform #(.FRAC_BITS(FRAC_BITS), .LOAD_OP(OP_LOAD_VIEW)) u_view (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .tag_i(tag0_r), .p_i(pt_r), .tag_o(tag1), .q_o(vp)
  );

  wsp_xform #(.FRAC_BITS(FRAC_BITS), .LOAD_OP(OP_LOAD_PROJ)) u_proj (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .tag_i(tag1), .p_i(vp), .tag_o(tag2), .q_o(cp)
  );

  assign meta_c.vld = tag2.vld;
  assign meta_c.res = tag2.op == OP_PROJECT;
  assign meta_c.ok  = cam_r && (cp[3] >= W_MIN);

  wsp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .ce(ce), .meta_i(meta_c),
    .cx_i(cp[0]), .cy_i(cp[1]), .cw_i(cp[3]),
    .meta_o(meta_d), .nx_o(nx), .ny_o(ny)
  );

  wsp_map #(.FRAC_BITS(FRAC_BITS)) u_map (
    .clk(clk), .rst_n(rst_n), .ce(ce), .meta_i(meta_d),
    .nx_i(nx), .ny_i(ny), .width_i(width_r), .height_i(height_r),
    .valid_o(out_tvalid), .sx_o(sx), .sy_o(sy), .proj_o(proj), .vis_o(vis)
  );

  assign out_tdata = {sy, sx};
  assign out_tuser = {vis, proj};

  a_vis_needs_proj: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("on-screen flag without projection");

  a_unproj_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 64'd0)
    else $error("unprojected result carries coordinates");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output word changed");

  a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while pipeline frozen");

endmodule

// ===== design/wsp_xform.sv =====
module wsp_xform #(
  parameter int FRAC_BITS = 16,
  parameter logic [1:0] LOAD_OP = 2'd0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ce,
  input  wsp_pkg::tag_t       tag_i,
  input  logic signed [31:0]  p_i [4],
  output wsp_pkg::tag_t       tag_o,
  output logic signed [31:0]  q_o [4]
);
  import wsp_pkg::*;

  localparam int SW = 64 - FRAC_BITS;
  localparam int AW = SW + 2;

  logic signed [31:0] mat_r [16];
  logic signed [SW-1:0] prod_r [16];
  tag_t tag1_r;
  logic signed [AW-1:0] acc [4];

  // The matrix is written as the load word passes, so words ahead of it
  // still see the old element and words behind it see the new one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) mat_r[i] <= '0;
    end else if (ce && tag_i.vld && tag_i.op == LOAD_OP) begin
      mat_r[tag_i.idx] <= tag_i.val;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 16; i++) begin
        prod_r[i] <= SW'((64'(mat_r[i]) * 64'(p_i[i/4])) >>> FRAC_BITS);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      acc[r] = AW'(prod_r[r]) + AW'(prod_r[4+r]) + AW'(prod_r[8+r]) + AW'(prod_r[12+r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r.vld <= 1'b0;
      tag_o.vld  <= 1'b0;
    end else if (ce) begin
      tag1_r.vld <= tag_i.vld;
      tag_o.vld  <= tag1_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      tag1_r.op  <= tag_i.op;
      tag1_r.idx <= tag_i.idx;
      tag1_r.val <= tag_i.val;
      tag_o.op   <= tag1_r.op;
      tag_o.idx  <= tag1_r.idx;
      tag_o.val  <= tag1_r.val;
      for (int r = 0; r < 4; r++) begin
        if (acc[r] > AW'(64'sd2147483647)) q_o[r] <= 32'sh7FFFFFFF;
        else if (acc[r] < -AW'(64'sd2147483648)) q_o[r] <= 32'sh80000000;
        else q_o[r] <= acc[r][31:0];
      end
    end
  end

endmodule

// ===== design/wsp_div.sv =====
module wsp_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ce,
  input  wsp_pkg::meta_t                meta_i,
  input  logic signed [31:0]            cx_i,
  input  logic signed [31:0]            cy_i,
  input  logic signed [31:0]            cw_i,
  output wsp_pkg::meta_t                meta_o,
  output logic signed [32+FRAC_BITS:0]  nx_o,
  output logic signed [32+FRAC_BITS:0]  ny_o
);
  import wsp_pkg::*;

  localparam int DW = 32 + FRAC_BITS;

  // One quotient bit per stage, restoring form, two lanes sharing the divisor.
  meta_t             meta_r [DW+1];
  logic [30:0]       d_r    [DW+1];
  logic [31:0]       rx_r   [DW+1];
  logic [31:0]       ry_r   [DW+1];
  logic [DW-1:0]     qx_r   [DW+1];
  logic [DW-1:0]     qy_r   [DW+1];
  logic              sx_r   [DW+1];
  logic              sy_r   [DW+1];

  logic [31:0] ax, ay;

  assign ax = cx_i[31] ? 32'(-33'(cx_i)) : 32'(cx_i);
  assign ay = cy_i[31] ? 32'(-33'(cy_i)) : 32'(cy_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DW; k++) meta_r[k].vld <= 1'b0;
      meta_o.vld <= 1'b0;
    end else if (ce) begin
      meta_r[0].vld <= meta_i.vld;
      for (int k = 1; k <= DW; k++) meta_r[k].vld <= meta_r[k-1].vld;
      meta_o.vld <= meta_r[DW].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      meta_r[0].res <= meta_i.res;
      meta_r[0].ok  <= meta_i.ok;
      d_r[0]  <= meta_i.ok ? cw_i[30:0] : 31'd1;
      rx_r[0] <= '0;
      ry_r[0] <= '0;
      qx_r[0] <= {ax, FRAC_BITS'(0)};
      qy_r[0] <= {ay, FRAC_BITS'(0)};
      sx_r[0] <= cx_i[31];
      sy_r[0] <= cy_i[31];
    end
  end

  for (genvar k = 1; k <= DW; k++) begin : g_step
    logic [32:0] tx, ty;
    logic        bx, by;
    assign tx = {rx_r[k-1], qx_r[k-1][DW-1]};
    assign ty = {ry_r[k-1], qy_r[k-1][DW-1]};
    assign bx = tx >= {2'b00, d_r[k-1]};
    assign by = ty >= {2'b00, d_r[k-1]};
    always_ff @(posedge clk) begin
      if (ce) begin
        meta_r[k].res <= meta_r[k-1].res;
        meta_r[k].ok  <= meta_r[k-1].ok;
        d_r[k]  <= d_r[k-1];
        sx_r[k] <= sx_r[k-1];
        sy_r[k] <= sy_r[k-1];
        rx_r[k] <= bx ? 32'(tx - {2'b00, d_r[k-1]}) : tx[31:0];
        ry_r[k] <= by ? 32'(ty - {2'b00, d_r[k-1]}) : ty[31:0];
        qx_r[k] <= {qx_r[k-1][DW-2:0], bx};
        qy_r[k] <= {qy_r[k-1][DW-2:0], by};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      meta_o.res <= meta_r[DW].res;
      meta_o.ok  <= meta_r[DW].ok;
      nx_o <= sx_r[DW] ? -$signed({1'b0, qx_r[DW]}) : $signed({1'b0, qx_r[DW]});
      ny_o <= sy_r[DW] ? -$signed({1'b0, qy_r[DW]}) : $signed({1'b0, qy_r[DW]});
    end
  end

endmodule

// ===== design/wsp_map.sv =====
module wsp_map #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ce,
  input  wsp_pkg::meta_t                meta_i,
  input  logic signed [32+FRAC_BITS:0]  nx_i,
  input  logic signed [32+FRAC_BITS:0]  ny_i,
  input  logic [13:0]                   width_i,
  input  logic [13:0]                   height_i,
  output logic                          valid_o,
  output logic signed [31:0]            sx_o,
  output logic signed [31:0]            sy_o,
  output logic                          proj_o,
  output logic                          vis_o
);
  import wsp_pkg::*;

  localparam int DW = 32 + FRAC_BITS;
  localparam int SW = DW + 2;
  localparam int PW = SW + 15;

  meta_t meta_r;
  logic signed [PW-1:0] px_r, py_r;
  logic signed [SW-1:0] ux, uy;
  logic signed [PW-1:0] sx, sy, one_p, margin, limx, limy;
  logic vis;

  assign ux = SW'(nx_i) + (SW'(1) <<< FRAC_BITS);
  assign uy = (SW'(1) <<< FRAC_BITS) - SW'(ny_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r.vld <= 1'b0;
      valid_o    <= 1'b0;
    end else if (ce) begin
      meta_r.vld <= meta_i.vld;
      valid_o    <= meta_r.vld && meta_r.res;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      meta_r.res <= meta_i.res;
      meta_r.ok  <= meta_i.ok;
      px_r <= PW'(ux) * PW'($signed({1'b0, width_i}));
      py_r <= PW'(uy) * PW'($signed({1'b0, height_i}));
    end
  end

  assign one_p  = PW'(1) <<< FRAC_BITS;
  assign margin = PW'(100) <<< FRAC_BITS;
  assign limx   = PW'($signed({1'b0, width_i})) * one_p + margin;
  assign limy   = PW'($signed({1'b0, height_i})) * one_p + margin;
  assign sx     = px_r >>> 1;
  assign sy     = py_r >>> 1;
  assign vis    = (sx > -margin) && (sx < limx) && (sy > -margin) && (sy < limy);

  always_ff @(posedge clk) begin
    if (ce) begin
      proj_o <= meta_r.ok;
      vis_o  <= meta_r.ok && vis;
      if (!meta_r.ok) sx_o <= '0;
      else if (sx > PW'(64'sd2147483647)) sx_o <= 32'sh7FFFFFFF;
      else if (sx < -PW'(64'sd2147483648)) sx_o <= 32'sh80000000;
      else sx_o <= sx[31:0];
      if (!meta_r.ok) sy_o <= '0;
      else if (sy > PW'(64'sd2147483647)) sy_o <= 32'sh7FFFFFFF;
      else if (sy < -PW'(64'sd2147483648)) sy_o <= 32'sh80000000;
      else sy_o <= sy[31:0];
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import wsp_pkg::*;

  localparam int FB = 16;
  localparam longint ONE = longint'(1) << FB;
  localparam longint CW_MIN = (ONE + 999) / 1000;
  localparam longint MARGIN = 100 * ONE;
  localparam int LATENCY = 41 + FB;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic        projected;
    logic        on_screen;
  } screen_pt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [135:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [13:0] cfg_wdata = '0;

  world_to_screen_projection_top dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow state of the block.
  logic signed [31:0] view_m [16];
  logic signed [31:0] proj_m [16];
  logic [13:0] scr_w, scr_h;
  logic cam_ok;

  screen_pt_t pending_pts[$];
  int errors = 0;
  int n_words = 0;
  int n_points = 0;
  int n_visible = 0;
  int n_configs = 0;
  bit idle_en = 1'b1;
  int quiet = 0;
  int stall_left = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint row_sum(bit use_proj, int r, longint p0, longint p1,
                                     longint p2, longint p3);
    longint acc;
    longint p [4];
    acc = 0;
    p[0] = p0; p[1] = p1; p[2] = p2; p[3] = p3;
    for (int c = 0; c < 4; c++) begin
      if (use_proj) acc += (longint'(proj_m[c*4 + r]) * p[c]) >>> FB;
      else acc += (longint'(view_m[c*4 + r]) * p[c]) >>> FB;
    end
    return sat32(acc);
  endfunction

  function automatic screen_pt_t project_point(logic signed [31:0] px,
                                               logic signed [31:0] py,
                                               logic signed [31:0] pz);
    longint v [4];
    longint cl [4];
    longint nx, ny, sx, sy, w, h;
    screen_pt_t res;
    for (int r = 0; r < 4; r++) v[r] = row_sum(1'b0, r, px, py, pz, ONE);
    for (int r = 0; r < 4; r++) cl[r] = row_sum(1'b1, r, v[0], v[1], v[2], v[3]);
    res = '0;
    if (!cam_ok || cl[3] < CW_MIN) return res;
    nx = (cl[0] * ONE) / cl[3];
    ny = (cl[1] * ONE) / cl[3];
    w = longint'(scr_w);
    h = longint'(scr_h);
    sx = ((nx + ONE) * w) >>> 1;
    sy = ((ONE - ny) * h) >>> 1;
    res.sx = 32'(sat32(sx));
    res.sy = 32'(sat32(sy));
    res.projected = 1'b1;
    res.on_screen = sx > -MARGIN && sx < w * ONE + MARGIN &&
                    sy > -MARGIN && sy < h * ONE + MARGIN;
    return res;
  endfunction

  task automatic send_word(logic [1:0] op, logic [3:0] idx, logic [31:0] val,
                           logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {4'b0, pz, py, px, val, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_words++;
    case (op)
      OP_LOAD_VIEW: view_m[idx] = val;
      OP_LOAD_PROJ: proj_m[idx] = val;
      OP_PROJECT: begin
        pending_pts.push_back(project_point(px, py, pz));
        n_points++;
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pts.size() != 0) @(posedge clk);
    // Loads may still be in flight behind the last result.
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] addr, logic [13:0] data);
    drain();
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      REG_WIDTH:  scr_w = data;
      REG_HEIGHT: scr_h = data;
      REG_CAMERA: cam_ok = data[0];
      default: ;
    endcase
    n_configs++;
    @(posedge clk);
  endtask

  task automatic load_matrix(logic [1:0] op, logic signed [31:0] m [16]);
    for (int i = 0; i < 16; i++) send_word(op, i[3:0], m[i], '0, '0, '0);
  endtask

  task automatic point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send_word(OP_PROJECT, '0, '0, x, y, z);
  endtask

  // Identity view; projection gives clip w = view z, so z picks the divisor.
  task automatic test_directed();
    logic signed [31:0] m [16];
    point(32'h7fffffff, 32'h80000000, 32'h12345678);  // camera still invalid
    write_reg(REG_CAMERA, 14'd1);
    point('0, '0, '0);                                 // zero matrices
    for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'(ONE) : 32'd0;
    load_matrix(OP_LOAD_VIEW, m);
    m[15] = 0;
    m[11] = 32'(ONE);
    load_matrix(OP_LOAD_PROJ, m);
    point(32'h00008000, 32'h0000c000, 32'd65);        // just below minimum w
    point(32'h00000010, 32'hfffffff0, 32'd66);        // exactly minimum w
    point(32'h00008000, 32'hffff8000, 32'h00010000);
    point(32'h7fffffff, 32'h7fffffff, 32'h00010000);
    point(32'h80000000, 32'h80000000, 32'h00010000);
    point('0, '0, 32'hffff0000);                       // negative w
    point(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_word(2'd3, 4'hf, 32'hffffffff, '1, '1, '1);  // unused opcode
    send_word(OP_LOAD_VIEW, 4'hf, 32'h80000000, '0, '0, '0);
    send_word(OP_LOAD_PROJ, 4'h0, 32'h7fffffff, '0, '0, '0);
    point(32'h00010000, 32'h00010000, 32'h00010000);
    drain();
  endtask

  task automatic test_screen_sizes();
    write_reg(REG_WIDTH, 14'd16383);
    write_reg(REG_HEIGHT, 14'd1);
    for (int i = 0; i < 4; i++) point($urandom, $urandom, $urandom_range(1, 3) << 16);
    write_reg(REG_WIDTH, 14'd0);
    write_reg(REG_HEIGHT, 14'd16383);
    for (int i = 0; i < 4; i++) point($urandom, $urandom, $urandom_range(1, 3) << 16);
    write_reg(REG_WIDTH, 14'd1);
    write_reg(REG_HEIGHT, 14'd0);
    point($urandom, $urandom, 32'h00020000);
  endtask

  function automatic logic [31:0] small_fx(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // A well-formed camera: small view transform and perspective-like
  // projection whose w row follows view z, then mostly sane points.
  task automatic test_random_camera(int n_pts);
    logic signed [31:0] m [16];
    if ($urandom_range(0, 2) == 0) begin
      write_reg(REG_WIDTH, $urandom_range(0, 3) == 0 ? 14'($urandom_range(0, 16383))
                                                     : 14'($urandom_range(320, 4096)));
      write_reg(REG_HEIGHT, $urandom_range(0, 3) == 0 ? 14'($urandom_range(0, 16383))
                                                      : 14'($urandom_range(240, 2160)));
      write_reg(REG_CAMERA, 14'($urandom_range(0, 4) != 0));
    end
    for (int i = 0; i < 16; i++) m[i] = small_fx(1 << 16);
    for (int i = 0; i < 4; i++) m[i*5] = 32'(ONE) + small_fx(1 << 14);
    m[12] = small_fx(5 << 16); m[13] = small_fx(5 << 16); m[14] = small_fx(5 << 16);
    if ($urandom_range(0, 9) == 0) m[$urandom_range(0, 15)] = $urandom;
    load_matrix(OP_LOAD_VIEW, m);
    for (int i = 0; i < 16; i++) m[i] = small_fx(1 << 13);
    m[0] = $urandom_range(1 << 15, 3 << 16);
    m[5] = $urandom_range(1 << 15, 3 << 16);
    m[11] = 32'(ONE);
    m[15] = small_fx(1 << 12);
    if ($urandom_range(0, 9) == 0) m[$urandom_range(0, 15)] = $urandom;
    load_matrix(OP_LOAD_PROJ, m);
    for (int i = 0; i < n_pts; i++) begin
      case ($urandom_range(0, 9))
        0: point($urandom, $urandom, $urandom);
        1: send_word(2'($urandom_range(0, 3)), 4'($urandom), $urandom, $urandom,
                     $urandom, $urandom);
        default: point(small_fx(8 << 16), small_fx(8 << 16),
                       $urandom_range(0, 20 << 16));
      endcase
    end
  endtask

  // The receiver stalls in random bursts.
  always @(posedge clk) begin
    if (!rst_n || !idle_en) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_tready <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(1, 10);
    end
  end

  always @(posedge clk) begin
    screen_pt_t exp_pt;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pts.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h flags=%b", $realtime,
                 out_tdata[31:0], out_tdata[63:32], out_tuser);
        errors++;
      end else begin
        exp_pt = pending_pts.pop_front();
        if (exp_pt.on_screen) n_visible++;
        if (out_tdata[31:0] !== exp_pt.sx) begin
          $display("%0t: screen_x expected %h actual %h", $realtime, exp_pt.sx,
                   out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[63:32] !== exp_pt.sy) begin
          $display("%0t: screen_y expected %h actual %h", $realtime, exp_pt.sy,
                   out_tdata[63:32]);
          errors++;
        end
        if (out_tuser[0] !== exp_pt.projected) begin
          $display("%0t: projected expected %b actual %b", $realtime,
                   exp_pt.projected, out_tuser[0]);
          errors++;
        end
        if (out_tuser[1] !== exp_pt.on_screen) begin
          $display("%0t: on_screen expected %b actual %b", $realtime,
                   exp_pt.on_screen, out_tuser[1]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n)
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 16; i++) begin
      view_m[i] = '0;
      proj_m[i] = '0;
    end
    scr_w = 14'd1920;
    scr_h = 14'd1080;
    cam_ok = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_screen_sizes();
    write_reg(REG_WIDTH, 14'd1920);
    write_reg(REG_HEIGHT, 14'd1080);
    for (int r = 0; r < 10; r++) test_random_camera(15 + $urandom_range(0, 10));
    idle_en = 1'b0;
    test_random_camera(20);
    drain();
    if (pending_pts.size() != 0) errors++;
    $display("Covered %0d words, %0d points (%0d on screen), %0d register writes,",
             n_words, n_points, n_visible, n_configs);
    $display("including invalid camera, minimum w, zero and maximum screen sizes.");
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/wsp_pkg.sv
design/wsp_xform.sv
design/wsp_div.sv
design/wsp_map.sv
design/world_to_screen_projection_top.sv
tb/tb.sv
